// ===== rtl/wpng_pkg.sv =====
// ----------------------------------------------------------------------------
// wpng_pkg
// Shared types and constants for the word phrase n-gram generator.
// ----------------------------------------------------------------------------
package wpng_pkg;

  // Field widths
  localparam int TOK_W   = 8;
  localparam int TAG_W   = 8;
  localparam int WORDS_W = 5;
  localparam int CHARS_W = 12;
  localparam int MNC_W   = 10;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 2;

  // Saturation limits of the result fields
  localparam logic [CHARS_W-1:0] CHARS_MAX = '1;
  localparam logic [WORDS_W-1:0] WORDS_MAX = '1;

  // Parameter defaults
  localparam int WINDOW_DEPTH_DEF    = 16;
  localparam int MAX_TOKEN_CHARS_DEF = 255;

  // Register reset values
  localparam logic [WORDS_W-1:0] MIN_WORDS_RST = 5'd1;
  localparam logic [WORDS_W-1:0] MAX_WORDS_RST = 5'd2;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MIN_WORDS = 2'd0,
    REG_MAX_WORDS = 2'd1,
    REG_MIN_CHARS = 2'd2,
    REG_MAX_CHARS = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Control shared by every window cell
  typedef struct packed {
    logic shift;  // take a new word in: hold and scan both load from the left
    logic step;   // walk one word: scan loads from the right
  } cell_ctl_t;

endpackage

// ===== rtl/wpng_cell.sv =====
// ----------------------------------------------------------------------------
// wpng_cell
// One window entry: a held word length and a scan copy used by the walk.
// ----------------------------------------------------------------------------
module wpng_cell
  import wpng_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [TOK_W-1:0] hold_in,   // left neighbor (newer word)
  input  logic [TOK_W-1:0] scan_in,   // right neighbor (older word)
  output logic [TOK_W-1:0] hold_out,
  output logic [TOK_W-1:0] scan_out
);

  logic [TOK_W-1:0] hold;
  logic [TOK_W-1:0] scan;

  // Window shift on a new item; scan copy follows the updated window and loads from the right on a walk step
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hold <= hold_in;
      scan <= hold_in;
    end else if (ctl.step) begin
      scan <= scan_in;
    end
  end

  assign hold_out = hold;
  assign scan_out = scan;

endmodule

// ===== rtl/word_phrase_ngram_generator.sv =====
// ----------------------------------------------------------------------------
// word_phrase_ngram_generator
// Each item shifts into the window and starts a walk; a new item is taken
//   only once the walk and the flush of the last one are done.
// The walk moves one word a cycle through the scan chain of the cells and
//   ends at the held words or at the first phrase that stops it.
// Output stalls hold the walk where a result cannot be handed on.
// Reset: synchronous; empties the window and loads register defaults.
// ----------------------------------------------------------------------------
module word_phrase_ngram_generator
  import wpng_pkg::*;
#(
  parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TOK_W-1:0]   token_length,
  input  logic               start_doc,
  input  logic [TAG_W-1:0]   prefix_tag,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORDS_W-1:0] phrase_words,
  output logic [CHARS_W-1:0] phrase_chars,
  output logic [TAG_W-1:0]   out_prefix_tag,
  output logic               last
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int LEN_W = $clog2(WINDOW_DEPTH * (2 ** TOK_W) + 1);
  localparam int CMP_W = 32;

  // Configuration registers
  logic [WORDS_W-1:0] words_floor;
  logic [WORDS_W-1:0] words_cap;
  logic [MNC_W-1:0]   chars_floor;
  logic [CHARS_W-1:0] chars_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_floor <= MIN_WORDS_RST;
      words_cap   <= MAX_WORDS_RST;
      chars_floor <= '0;
      chars_cap   <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_WORDS: words_floor <= cfg_data[WORDS_W-1:0];
        REG_MAX_WORDS: words_cap   <= cfg_data[WORDS_W-1:0];
        REG_MIN_CHARS: chars_floor <= cfg_data[MNC_W-1:0];
        REG_MAX_CHARS: chars_cap   <= cfg_data[CHARS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   words_held, words_held_next;
  logic [CNT_W-1:0]   walk_idx, walk_idx_next;
  logic [LEN_W-1:0]   len_acc, len_acc_next;
  logic [TAG_W-1:0]   tag;
  logic               pend_valid, pend_valid_next;
  logic [WORDS_W-1:0] pend_words, pend_words_next;
  logic [CHARS_W-1:0] pend_chars, pend_chars_next;
  logic               push, push_last;
  cell_ctl_t          ctl;

  // Window chain
  logic [TOK_W-1:0] hold_q [WINDOW_DEPTH];
  logic [TOK_W-1:0] scan_q [WINDOW_DEPTH];
  logic [TOK_W-1:0] tok_clamped;

  assign tok_clamped = (CMP_W'(token_length) > CMP_W'(MAX_TOKEN_CHARS))
                       ? TOK_W'(MAX_TOKEN_CHARS) : token_length;

  genvar g;
  generate
    for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      logic [TOK_W-1:0] left_w;
      logic [TOK_W-1:0] right_w;
      if (g == 0) begin : g_head
        assign left_w = tok_clamped;
      end else begin : g_body
        assign left_w = hold_q[g-1];
      end
      if (g == WINDOW_DEPTH - 1) begin : g_tail
        assign right_w = '0;
      end else begin : g_mid
        assign right_w = scan_q[g+1];
      end
      wpng_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .hold_in  (left_w),
        .scan_in  (right_w),
        .hold_out (hold_q[g]),
        .scan_out (scan_q[g])
      );
    end
  endgenerate

  // Window limit and new fill count
  logic [MNC_W-1:0] lim_raw;
  logic [CNT_W-1:0] lim_c;
  logic [CNT_W-1:0] held0;
  logic [CNT_W-1:0] keep;

  always_comb begin
    lim_raw = (chars_floor != '0) ? chars_floor : MNC_W'(words_cap);
    if (CMP_W'(lim_raw) > CMP_W'(WINDOW_DEPTH)) lim_c = CNT_W'(WINDOW_DEPTH);
    else                                          lim_c = CNT_W'(lim_raw);
    if (lim_c == '0) lim_c = CNT_W'(1);
    held0 = start_doc ? '0 : words_held;
    keep  = (held0 > lim_c - CNT_W'(1)) ? lim_c - CNT_W'(1) : held0;
  end

  // One walk step: phrase ending at the newest word, walk_idx+1 words long
  logic [CNT_W-1:0] step_words;
  logic [LEN_W-1:0] step_len;
  logic             stop_max, stop_words, stop, emit;
  logic             out_free;

  always_comb begin
    step_words = walk_idx + CNT_W'(1);
    step_len   = len_acc + LEN_W'(scan_q[0]) + LEN_W'(walk_idx != '0);
    stop_max   = (chars_cap != '0) &&
                 (CMP_W'(step_len) > CMP_W'(chars_cap));
    stop_words = (CMP_W'(step_words) > CMP_W'(words_cap)) &&
                 ((chars_floor == '0) ||
                  (CMP_W'(step_len) > CMP_W'(chars_floor)));
    stop       = stop_max || stop_words;
    emit       = !stop && (CMP_W'(step_words) >= CMP_W'(words_floor));
    out_free   = !out_valid || out_ready;
  end

  // Sequencer: next state and controls
  always_comb begin
    state_next      = state;
    words_held_next = words_held;
    walk_idx_next   = walk_idx;
    len_acc_next    = len_acc;
    pend_valid_next = pend_valid;
    pend_words_next = pend_words;
    pend_chars_next = pend_chars;
    push            = 1'b0;
    push_last       = 1'b0;
    ctl             = '0;
    in_ready        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.shift       = 1'b1;
          words_held_next = keep + CNT_W'(1);
          walk_idx_next   = '0;
          len_acc_next    = '0;
          state_next      = ST_WALK;
        end
      end
      ST_WALK: begin
        // a second phrase found while one waits needs the output register
        if (!(emit && pend_valid && !out_free)) begin
          if (stop) begin
            state_next = ST_FLUSH;
          end else begin
            if (emit) begin
              push            = pend_valid;
              pend_valid_next = 1'b1;
              pend_words_next = (CMP_W'(step_words) > CMP_W'(WORDS_MAX))
                                ? WORDS_MAX : WORDS_W'(step_words);
              pend_chars_next = (CMP_W'(step_len) > CMP_W'(CHARS_MAX))
                                ? CHARS_MAX : CHARS_W'(step_len);
            end
            ctl.step      = 1'b1;
            len_acc_next  = step_len;
            walk_idx_next = step_words;
            if (step_words == words_held) state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // the phrase still held is the final one of this item
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          push_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      words_held <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      words_held <= words_held_next;
      pend_valid <= pend_valid_next;
      if (push)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Walk and result payload
  always_ff @(posedge clk) begin
    walk_idx   <= walk_idx_next;
    len_acc    <= len_acc_next;
    pend_words <= pend_words_next;
    pend_chars <= pend_chars_next;
    if (in_valid && in_ready) tag <= prefix_tag;
    if (push) begin
      phrase_words   <= pend_words;
      phrase_chars   <= pend_chars;
      out_prefix_tag <= tag;
      last           <= push_last;
    end
  end

  // Checks
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("pending phrase left over when a new item is taken");

  a_held_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> (words_held != '0) &&
      (CMP_W'(words_held) <= CMP_W'(WINDOW_DEPTH)))
    else $error("window fill count out of range after an item");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> walk_idx < words_held)
    else $error("walk ran past the held words");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free && pend_valid)
    else $error("result pushed into a busy output register");

  a_pend_words: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend_words != '0)
    else $error("pending phrase with no words");

endmodule
